// ----- sv/suc_pkg.sv -----
// Package for the sorted unique set.
// Holds the beat types, operation and status codes, controller states and
// the control word for the cell chain. It depends on nothing.
package suc_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_LISTED    = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] entry;
        logic               last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_DUMP
    } t_state;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_CMP,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic signed [31:0] key;
    } t_cell_ctl;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flag;

endpackage

// ----- sv/suc_cell.sv -----
// One cell of the sorted chain: holds one stored value and its compare flags.
// Depends on suc_pkg for the control word and flag types.
module suc_cell (
    input  logic                i_clk,
    input  suc_pkg::t_cell_ctl  i_ctl,
    input  logic                i_vld,
    input  logic                i_left_lt,
    input  logic signed [31:0]  i_left_val,
    input  logic                i_right_vld,
    input  logic signed [31:0]  i_right_val,
    input  logic signed [31:0]  i_head_val,
    output logic signed [31:0]  o_val,
    output suc_pkg::t_cell_flag o_flag
);
    import suc_pkg::*;

    logic signed [31:0] r_val;
    t_cell_flag         r_flag;

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CELL_CMP: begin
                r_flag.lt <= i_vld && (r_val < i_ctl.key);
                r_flag.eq <= i_vld && (r_val == i_ctl.key);
            end
            CELL_INS: begin
                if (!r_flag.lt) begin
                    r_val <= i_left_lt ? i_ctl.key : i_left_val;
                end
            end
            CELL_DEL: begin
                if (i_vld && !r_flag.lt) begin
                    r_val <= i_right_val;
                end
            end
            CELL_ROT: begin
                if (i_vld) begin
                    r_val <= i_right_vld ? i_right_val : i_head_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_val  = r_val;
    assign o_flag = r_flag;

endmodule

// ----- sv/sorted_unique_set.sv -----
// Sorted unique set of signed 32-bit values, up to CAPACITY entries, kept in
// a chain of cells. An insert or delete holds busy after its start beat
// through a compare step in every cell and an apply step that shifts the
// chain when the set changes, so no new item is taken before it is done; its
// single result is registered from the apply step. A dump rotates the chain
// one place per cycle and streams one listed entry per cycle, holding busy
// until the last entry is listed; a dump of an empty set and an unused
// operation code do not raise busy. Results are strobed for one cycle and
// cannot be held. Depends on suc_pkg and suc_cell.
module sorted_unique_set #(
    parameter int CAPACITY = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  suc_pkg::t_in  i_in,
    output logic          o_strobe,
    output suc_pkg::t_out o_result
);
    import suc_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left, n_left;
    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_key, n_key;
    logic               r_strobe, n_strobe;
    t_out               r_result, n_result;

    t_cell_ctl          w_ctl;
    logic signed [31:0] w_val [CAPACITY];
    t_cell_flag         w_flag [CAPACITY];
    logic [CAPACITY-1:0] w_vld;
    logic [CAPACITY-1:0] w_eq;
    logic               w_any_eq;
    logic               w_full;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic               w_left_lt;
            logic signed [31:0] w_left_val;
            logic               w_right_vld;
            logic signed [31:0] w_right_val;

            assign w_vld[g] = (r_count > CW'(g));
            assign w_eq[g]  = w_flag[g].eq;

            if (g == 0) begin : g_first
                assign w_left_lt  = 1'b1;
                assign w_left_val = w_val[0];
            end else begin : g_inner
                assign w_left_lt  = w_flag[g-1].lt;
                assign w_left_val = w_val[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_right_vld = 1'b0;
                assign w_right_val = w_val[g];
            end else begin : g_mid
                assign w_right_vld = w_vld[g+1];
                assign w_right_val = w_val[g+1];
            end

            suc_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_vld       (w_vld[g]),
                .i_left_lt   (w_left_lt),
                .i_left_val  (w_left_val),
                .i_right_vld (w_right_vld),
                .i_right_val (w_right_val),
                .i_head_val  (w_val[0]),
                .o_val       (w_val[g]),
                .o_flag      (w_flag[g])
            );
        end
    endgenerate

    assign w_any_eq = |w_eq;
    assign w_full   = (r_count == CW'(CAPACITY));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_in.operation)
                        OP_INSERT, OP_DELETE: n_state = S_CMP;
                        OP_DUMP: n_state = (r_count == '0) ? S_IDLE : S_DUMP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CMP:   n_state = S_APPLY;
            S_APPLY: n_state = S_IDLE;
            S_DUMP:  n_state = (r_left == CW'(1)) ? S_IDLE : S_DUMP;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_left    = r_left;
        n_op      = r_op;
        n_key     = r_key;
        n_strobe  = 1'b0;
        n_result  = r_result;
        w_ctl.cmd = CELL_NOP;
        w_ctl.key = r_key;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_in.operation;
                    n_key = i_in.value;
                    if (i_in.operation == OP_DUMP) begin
                        n_left = r_count;
                        if (r_count == '0) begin
                            n_strobe        = 1'b1;
                            n_result.status = ST_EMPTY;
                            n_result.entry  = '0;
                            n_result.last   = 1'b1;
                        end
                    end
                end
            end
            S_CMP: begin
                w_ctl.cmd = CELL_CMP;
            end
            S_APPLY: begin
                n_strobe       = 1'b1;
                n_result.entry = r_key;
                n_result.last  = 1'b1;
                if (r_op == OP_INSERT) begin
                    if (w_any_eq) begin
                        n_result.status = ST_DUPLICATE;
                    end else if (w_full) begin
                        n_result.status = ST_FULL;
                    end else begin
                        w_ctl.cmd       = CELL_INS;
                        n_count         = r_count + CW'(1);
                        n_result.status = ST_INSERTED;
                    end
                end else begin
                    if (w_any_eq) begin
                        w_ctl.cmd       = CELL_DEL;
                        n_count         = r_count - CW'(1);
                        n_result.status = ST_DELETED;
                    end else begin
                        n_result.status = ST_NOT_FOUND;
                    end
                end
            end
            S_DUMP: begin
                w_ctl.cmd       = CELL_ROT;
                n_strobe        = 1'b1;
                n_result.status = ST_LISTED;
                n_result.entry  = w_val[0];
                n_result.last   = (r_left == CW'(1));
                n_left          = r_left - CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_left   <= n_left;
        r_op     <= n_op;
        r_key    <= n_key;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && (r_result.status == ST_INSERTED) && $past(i_rst_n)
        |-> r_count == $past(r_count) + CW'(1))
        else $error("Insert result without growth of the set.");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && (r_result.status == ST_DELETED) && $past(i_rst_n)
        |-> r_count == $past(r_count) - CW'(1))
        else $error("Delete result without shrink of the set.");

    a_dump_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_result.last && (r_result.status == ST_LISTED) |-> !busy)
        else $error("Controller still busy after the last listed beat.");
`endif

endmodule

// ----- tb/tb_sorted_unique_set.sv -----
// Self-checking testbench for sorted_unique_set: directed and random insert,
// delete and dump beats, checked against a scoreboard that tracks the set.
// Depends on suc_pkg and the sorted_unique_set RTL.
module tb_sorted_unique_set;
    import suc_pkg::*;

    localparam int CAPACITY = 32;
    localparam int CLK_HALF = 4;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    class set_scoreboard;
        logic signed [31:0] members [CAPACITY];
        int                 count;
        t_out               pending_results[$];
        int                 errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void note_request(t_in req);
            int   pos;
            t_out res;
            res.status = ST_INSERTED;
            res.entry  = req.value;
            res.last   = 1'b1;
            case (req.operation)
                OP_INSERT: begin
                    pos = 0;
                    while (pos < count && members[pos] < req.value) pos++;
                    if (pos < count && members[pos] == req.value) begin
                        res.status = ST_DUPLICATE;
                    end else if (count >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        for (int i = count; i > pos; i--) members[i] = members[i - 1];
                        members[pos] = req.value;
                        count++;
                        res.status = ST_INSERTED;
                    end
                    pending_results.push_back(res);
                end
                OP_DELETE: begin
                    pos = 0;
                    while (pos < count && members[pos] != req.value) pos++;
                    if (pos >= count) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        for (int i = pos; i + 1 < count; i++) members[i] = members[i + 1];
                        count--;
                        res.status = ST_DELETED;
                    end
                    pending_results.push_back(res);
                end
                OP_DUMP: begin
                    if (count == 0) begin
                        res.status = ST_EMPTY;
                        res.entry  = '0;
                        pending_results.push_back(res);
                    end else begin
                        for (int i = 0; i < count; i++) begin
                            res.status = ST_LISTED;
                            res.entry  = members[i];
                            res.last   = (i == count - 1);
                            pending_results.push_back(res);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d, entry %0d, last %0b",
                       got.status, got.entry, got.last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.entry !== want.entry) begin
                $error("entry: expected %0d, actual %0d", want.entry, got.entry);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    t_in           i_in;
    logic          o_strobe;
    t_out          o_result;
    set_scoreboard sb;

    sorted_unique_set #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_result(o_result);
            if (start && !busy) sb.note_request(i_in);
        end
    end

    function automatic t_in make_item(input logic [1:0] op, input logic signed [31:0] val);
        t_in item;
        item.operation = op;
        item.value     = val;
        return item;
    endfunction

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        int                 roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
            v = $urandom_range(0, 47);
            v = v - 24;
        end else if (roll == 7) begin
            case ($urandom_range(0, 3))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = '0;
                default: v = -1;
            endcase
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    function automatic logic [1:0] pick_op(input int phase);
        int roll;
        int ins_lim;
        int del_lim;
        roll = $urandom_range(0, 99);
        case (phase)
            0: begin
                ins_lim = 75;
                del_lim = 88;
            end
            1: begin
                ins_lim = 20;
                del_lim = 80;
            end
            default: begin
                ins_lim = 45;
                del_lim = 85;
            end
        endcase
        if (roll < ins_lim) return OP_INSERT;
        if (roll < del_lim) return OP_DELETE;
        if (roll < 97) return OP_DUMP;
        return OP_UNUSED;
    endfunction

    task automatic send_item(input t_in item);
        logic taken;
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= item;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
    endtask

    task automatic pause(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int phase_len [3];
        int burst_left;
        sb       = new();
        start    = 1'b0;
        i_in     = '0;
        i_rst_n  = 1'b0;
        phase_len = '{120, 100, 120};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(make_item(OP_DUMP, 32'sd5));
        send_item(make_item(OP_UNUSED, 32'sd7));
        send_item(make_item(OP_INSERT, 32'sd0));
        send_item(make_item(OP_INSERT, VAL_MAX));
        send_item(make_item(OP_INSERT, VAL_MIN));
        send_item(make_item(OP_INSERT, -32'sd1));
        send_item(make_item(OP_INSERT, 32'sd1));
        send_item(make_item(OP_INSERT, 32'sd0));
        send_item(make_item(OP_DELETE, 32'sd5));
        send_item(make_item(OP_DUMP, 32'sd0));
        pause(3);
        send_item(make_item(OP_DELETE, VAL_MIN));
        send_item(make_item(OP_DELETE, VAL_MAX));
        send_item(make_item(OP_DELETE, VAL_MAX));
        send_item(make_item(OP_DUMP, -32'sd1));
        send_item(make_item(OP_DELETE, -32'sd1));
        send_item(make_item(OP_DELETE, 32'sd0));
        send_item(make_item(OP_DELETE, 32'sd1));
        send_item(make_item(OP_DUMP, VAL_MAX));
        send_item(make_item(OP_INSERT, VAL_MIN));
        send_item(make_item(OP_INSERT, VAL_MAX));
        send_item(make_item(OP_DELETE, VAL_MIN));
        send_item(make_item(OP_DELETE, VAL_MAX));
        drain();

        burst_left = $urandom_range(1, 10);
        for (int phase = 0; phase < 3; phase++) begin
            for (int k = 0; k < phase_len[phase]; k++) begin
                send_item(make_item(pick_op(phase), pick_value()));
                burst_left--;
                if (burst_left == 0) begin
                    pause($urandom_range(0, 6));
                    burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
                end
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(CLK_HALF * 2 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sorted_unique_set.f -----
sv/suc_pkg.sv
sv/suc_cell.sv
sv/sorted_unique_set.sv
tb/tb_sorted_unique_set.sv
